// ----- hw/rtl/road_segment_quad_expander_unit_assert.svh -----
// Assertion macros shared by the road segment quad expander RTL.
`ifndef ROAD_SEGMENT_QUAD_EXPANDER_UNIT_ASSERT_SVH
`define ROAD_SEGMENT_QUAD_EXPANDER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, off while reset is asserted (active low).
`define RSQE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, off while reset is asserted (active low).
`define RSQE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSQE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RSQE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/rsqe_pkg.sv -----
// Shared constants, types and helpers for the road segment quad expander.
package rsqe_pkg;

    localparam int COORD_BITS = 20;
    localparam int FRAC_BITS  = 8;
    localparam int DIST_BITS  = 16;
    localparam int OUT_BITS   = COORD_BITS + FRAC_BITS;
    localparam logic [DIST_BITS-1:0] DIST_RESET = DIST_BITS'(256);

    // |delta| of two coordinates
    localparam int DELTA_BITS = COORD_BITS + 1;
    // shared multiplier operand and product
    localparam int MUL_BITS   = (DELTA_BITS > DIST_BITS) ? DELTA_BITS : DIST_BITS;
    localparam int PROD_BITS  = 2 * MUL_BITS;
    // dx^2 + dy^2
    localparam int SUM_BITS   = 2 * DELTA_BITS;
    // dist * |delta| and its split for squaring
    localparam int P_BITS     = DIST_BITS + DELTA_BITS;
    localparam int P_LO_BITS  = P_BITS - P_BITS / 2;
    localparam int P_HI_BITS  = P_BITS - P_LO_BITS;
    // search accumulators, signed, with headroom
    localparam int WIDE_BITS  = 2 * P_BITS + 6;
    // top result bit that can be set (result never exceeds dist)
    localparam int Q_TOP      = DIST_BITS - 1;
    localparam int IDX_BITS   = $clog2(DIST_BITS);

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_CALC,
        TS_EMIT
    } t_top_state;

    typedef enum logic [3:0] {
        RT_IDLE,
        RT_SQX,
        RT_SQY,
        RT_PROD,
        RT_HH,
        RT_HL,
        RT_LL,
        RT_WFIN,
        RT_ADD,
        RT_CMP
    } t_ratio_state;

    typedef struct packed {
        logic                  start;
        logic [DELTA_BITS-1:0] adx;
        logic [DELTA_BITS-1:0] ady;
        logic [DIST_BITS-1:0]  distance;
    } t_ratio_req;

    typedef struct packed {
        logic                 done;
        logic [DIST_BITS-1:0] mx;
        logic [DIST_BITS-1:0] my;
    } t_ratio_rsp;

    // clamp a sum to the signed output range
    function automatic logic [OUT_BITS-1:0] sat_out(input logic signed [OUT_BITS:0] v);
        logic [OUT_BITS-1:0] res;
        if (v[OUT_BITS] != v[OUT_BITS-1]) begin
            res = v[OUT_BITS] ? {1'b1, {(OUT_BITS-1){1'b0}}} : {1'b0, {(OUT_BITS-1){1'b1}}};
        end else begin
            res = v[OUT_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/rsqe_ratio.sv -----
// Offset magnitude unit: one shared multiplier and one wide add/compare, sequenced.
`include "road_segment_quad_expander_unit_assert.svh"
module rsqe_ratio (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rsqe_pkg::t_ratio_req i_req,
    output rsqe_pkg::t_ratio_rsp o_rsp
);

    localparam int MB = rsqe_pkg::MUL_BITS;
    localparam int WB = rsqe_pkg::WIDE_BITS;
    localparam int PB = rsqe_pkg::P_BITS;
    localparam int PL = rsqe_pkg::P_LO_BITS;
    localparam int DB = rsqe_pkg::DIST_BITS;

    rsqe_pkg::t_ratio_state r_state, n_state;
    logic r_pass_y;
    logic r_done;

    logic [MB-1:0]                   w_mul_a, w_mul_b;
    logic [rsqe_pkg::PROD_BITS-1:0]  r_prod;
    logic [rsqe_pkg::SUM_BITS-1:0]   r_sum;
    logic [PB-1:0]                   r_p;
    logic signed [WB-1:0]            r_w;      // 4 * (dist*a)^2
    logic signed [WB-1:0]            r_acc;    // e^2 * S for e = 2q-1
    logic signed [WB-1:0]            r_cross;  // 4 * bit * e * S
    logic signed [WB-1:0]            r_quad;   // 4 * bit^2 * S
    logic signed [WB-1:0]            r_trial;
    logic signed [WB-1:0]            w_val;
    logic [DB-1:0]                   r_q, r_mx, r_my, w_cand, w_q_next;
    logic [rsqe_pkg::IDX_BITS-1:0]   r_idx;
    logic                            w_take;
    logic                            w_last_bit;

    // bit test: (2*cand-1)^2 * S <= 4 * dist^2 * a^2, cand <= dist
    assign w_cand     = r_q | (DB'(1) << r_idx);
    assign w_val      = r_trial + r_quad;
    assign w_take     = (w_cand <= i_req.distance) && (w_val <= r_w);
    assign w_q_next   = w_take ? w_cand : r_q;
    assign w_last_bit = (r_idx == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rsqe_pkg::RT_IDLE;
            r_pass_y <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == rsqe_pkg::RT_CMP) && w_last_bit && r_pass_y;
            if (r_state == rsqe_pkg::RT_IDLE) begin
                r_pass_y <= 1'b0;
            end else if (r_state == rsqe_pkg::RT_CMP && w_last_bit) begin
                r_pass_y <= 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            rsqe_pkg::RT_IDLE: begin
                if (i_req.start) n_state = rsqe_pkg::RT_SQX;
            end
            rsqe_pkg::RT_SQX: begin
                w_mul_a = MB'(i_req.adx);
                w_mul_b = MB'(i_req.adx);
                n_state = rsqe_pkg::RT_SQY;
            end
            rsqe_pkg::RT_SQY: begin
                w_mul_a = MB'(i_req.ady);
                w_mul_b = MB'(i_req.ady);
                n_state = rsqe_pkg::RT_PROD;
            end
            rsqe_pkg::RT_PROD: begin
                w_mul_a = MB'(i_req.distance);
                w_mul_b = r_pass_y ? MB'(i_req.adx) : MB'(i_req.ady);
                n_state = rsqe_pkg::RT_HH;
            end
            rsqe_pkg::RT_HH: begin
                w_mul_a = MB'(r_prod[PB-1:PL]);
                w_mul_b = MB'(r_prod[PB-1:PL]);
                n_state = rsqe_pkg::RT_HL;
            end
            rsqe_pkg::RT_HL: begin
                w_mul_a = MB'(r_p[PB-1:PL]);
                w_mul_b = MB'(r_p[PL-1:0]);
                n_state = rsqe_pkg::RT_LL;
            end
            rsqe_pkg::RT_LL: begin
                w_mul_a = MB'(r_p[PL-1:0]);
                w_mul_b = MB'(r_p[PL-1:0]);
                n_state = rsqe_pkg::RT_WFIN;
            end
            rsqe_pkg::RT_WFIN: n_state = rsqe_pkg::RT_ADD;
            rsqe_pkg::RT_ADD:  n_state = rsqe_pkg::RT_CMP;
            rsqe_pkg::RT_CMP: begin
                if (!w_last_bit)   n_state = rsqe_pkg::RT_ADD;
                else if (r_pass_y) n_state = rsqe_pkg::RT_IDLE;
                else               n_state = rsqe_pkg::RT_PROD;
            end
            default: n_state = rsqe_pkg::RT_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        unique case (r_state)
            rsqe_pkg::RT_SQY:  r_sum <= rsqe_pkg::SUM_BITS'(r_prod);
            rsqe_pkg::RT_PROD: begin
                if (!r_pass_y) r_sum <= r_sum + rsqe_pkg::SUM_BITS'(r_prod);
            end
            rsqe_pkg::RT_HH:   r_p <= r_prod[PB-1:0];
            rsqe_pkg::RT_HL:   r_w <= WB'(r_prod) << (2 * PL);
            rsqe_pkg::RT_LL:   r_w <= r_w + (WB'(r_prod) << (PL + 1));
            rsqe_pkg::RT_WFIN: begin
                r_w     <= (r_w + WB'(r_prod)) << 2;
                r_acc   <= WB'(r_sum);
                r_cross <= -(WB'(r_sum) << (rsqe_pkg::Q_TOP + 2));
                r_quad  <= WB'(r_sum) << (2 * rsqe_pkg::Q_TOP + 2);
                r_q     <= '0;
                r_idx   <= rsqe_pkg::IDX_BITS'(rsqe_pkg::Q_TOP);
            end
            rsqe_pkg::RT_ADD:  r_trial <= r_acc + r_cross;
            rsqe_pkg::RT_CMP: begin
                if (w_take) begin
                    r_acc   <= w_val;
                    r_cross <= (r_cross + (r_quad <<< 1)) >>> 1;
                end else begin
                    r_cross <= r_cross >>> 1;
                end
                r_quad <= r_quad >> 2;
                r_q    <= w_q_next;
                r_idx  <= r_idx - 1'b1;
                if (w_last_bit) begin
                    if (r_pass_y) r_my <= w_q_next;
                    else          r_mx <= w_q_next;
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.mx   = r_mx;
    assign o_rsp.my   = r_my;

    `RSQE_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_req.start, r_state == rsqe_pkg::RT_IDLE, "ratio start while busy")
    `RSQE_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done && r_state == rsqe_pkg::RT_IDLE, "done not a single pulse")
    `RSQE_ASSERT_IMP(a_q_bound, i_clk, i_rst_n, r_state == rsqe_pkg::RT_CMP, r_q <= i_req.distance, "partial result above distance")

endmodule

// ----- hw/rtl/road_segment_quad_expander_unit.sv -----
// Road segment quad expander: polyline points in, offset road rectangles out.
//
//  channel   dir  transaction carries
//  s_axis    in   one point: tdata = x, y; tuser = first of way; tlast = last of way
//  m_axis    out  one rectangle: tdata = 8 corner coords; tuser = zero length;
//                 tlast = closes way
//  cfg       in   offset_distance write (no handshake, no read-back)
//
//  A point that forms a segment of non-zero length occupies the block while the
//  shared 21x21 multiplier builds dx^2+dy^2 and (2*d*a)^2 and then the 80-bit
//  add/compare unit runs a 16-step bit search for each offset component. A point
//  that makes no segment leaves the block idle; a zero-length segment skips the
//  search. s_axis_tready is high only while the block is idle; the output
//  register lets a finished rectangle wait on m_axis while the next point is taken.
//  Reset is synchronous, active low; distance resets to 1.0 (256).
`include "road_segment_quad_expander_unit_assert.svh"
module road_segment_quad_expander_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [rsqe_pkg::DIST_BITS-1:0]      i_cfg_wdata,  // offset_distance
    // point stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [2*rsqe_pkg::COORD_BITS-1:0]   i_s_axis_tdata,  // point_x, point_y
    input  logic [0:0]                          i_s_axis_tuser,  // first_of_way
    input  logic                                i_s_axis_tlast,  // last_of_way
    // rectangle stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // start_right_x, start_right_y, end_right_x, end_right_y,
    // start_left_x, start_left_y, end_left_x, end_left_y
    output logic [8*rsqe_pkg::OUT_BITS-1:0]     o_m_axis_tdata,
    output logic [0:0]                          o_m_axis_tuser,  // zero_length
    output logic                                o_m_axis_tlast   // closes_way
);

    localparam int CB = rsqe_pkg::COORD_BITS;
    localparam int OB = rsqe_pkg::OUT_BITS;
    localparam int DB = rsqe_pkg::DELTA_BITS;

    rsqe_pkg::t_top_state r_state, n_state;

    logic [rsqe_pkg::DIST_BITS-1:0] r_dist;
    logic signed [CB-1:0] r_px, r_py;   // previous point, then segment end
    logic signed [CB-1:0] r_sx, r_sy;   // segment start
    logic                 r_pvalid;
    logic [DB-1:0]        r_adx, r_ady;
    logic                 r_neg, r_zero, r_last;
    logic                 r_go;

    logic                 r_ovalid;
    logic [8*OB-1:0]      r_odata;
    logic                 r_ozero, r_olast;

    logic                 w_in_acc, w_seg, w_load;
    logic signed [CB-1:0] w_x2, w_y2;
    logic signed [DB-1:0] w_dx, w_dy;
    logic                 w_zero;

    rsqe_pkg::t_ratio_req w_req;
    rsqe_pkg::t_ratio_rsp w_rsp;

    logic signed [OB:0]   w_ox, w_oy, w_sx1, w_sy1, w_sx2, w_sy2;
    logic signed [OB:0]   w_mx_ext, w_my_ext;

    // ------------------------------------------------------------------
    // input side
    assign w_x2     = i_s_axis_tdata[CB-1:0];
    assign w_y2     = i_s_axis_tdata[2*CB-1:CB];
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    // a segment needs a live previous point and no new-way mark
    assign w_seg    = w_in_acc && r_pvalid && !i_s_axis_tuser[0];

    // dx = x1 - x2, dy = y2 - y1
    assign w_dx   = {r_px[CB-1], r_px} - {w_x2[CB-1], w_x2};
    assign w_dy   = {w_y2[CB-1], w_y2} - {r_py[CB-1], r_py};
    assign w_zero = (w_dx == '0) && (w_dy == '0);

    assign o_s_axis_tready = (r_state == rsqe_pkg::TS_IDLE);

    // ------------------------------------------------------------------
    // offset magnitudes
    assign w_req.start    = r_go;
    assign w_req.adx      = r_adx;
    assign w_req.ady      = r_ady;
    assign w_req.distance = r_dist;

    rsqe_ratio u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // ------------------------------------------------------------------
    // sequencing
    assign w_load = (r_state == rsqe_pkg::TS_EMIT) && (!r_ovalid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsqe_pkg::TS_IDLE: begin
                if (w_seg) n_state = w_zero ? rsqe_pkg::TS_EMIT : rsqe_pkg::TS_CALC;
            end
            rsqe_pkg::TS_CALC: begin
                if (w_rsp.done) n_state = rsqe_pkg::TS_EMIT;
            end
            rsqe_pkg::TS_EMIT: begin
                if (w_load) n_state = rsqe_pkg::TS_IDLE;
            end
            default: n_state = rsqe_pkg::TS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rsqe_pkg::TS_IDLE;
            r_dist   <= rsqe_pkg::DIST_RESET;
            r_px     <= '0;
            r_py     <= '0;
            r_pvalid <= 1'b0;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= w_seg && !w_zero;
            if (i_cfg_we) r_dist <= i_cfg_wdata;
            if (w_in_acc) begin
                r_px     <= w_x2;
                r_py     <= w_y2;
                r_pvalid <= !i_s_axis_tlast;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // segment payload, captured on the transaction that forms it
    always_ff @(posedge i_clk) begin
        if (w_seg) begin
            r_sx   <= r_px;
            r_sy   <= r_py;
            r_adx  <= w_dx[DB-1] ? DB'(-w_dx) : DB'(w_dx);
            r_ady  <= w_dy[DB-1] ? DB'(-w_dy) : DB'(w_dy);
            // ox takes the sign of dx*dy; a horizontal segment keeps it positive
            r_neg  <= (w_dx[DB-1] != w_dy[DB-1]) && (w_dy != '0);
            r_zero <= w_zero;
            r_last <= i_s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // corners: endpoints in fixed point, plus and minus the offset, clamped
    assign w_mx_ext = {{(OB + 1 - rsqe_pkg::DIST_BITS){1'b0}}, w_rsp.mx};
    assign w_my_ext = {{(OB + 1 - rsqe_pkg::DIST_BITS){1'b0}}, w_rsp.my};
    assign w_ox     = r_zero ? '0 : (r_neg ? -w_mx_ext : w_mx_ext);
    assign w_oy     = r_zero ? '0 : w_my_ext;

    assign w_sx1 = {r_sx[CB-1], r_sx, {rsqe_pkg::FRAC_BITS{1'b0}}};
    assign w_sy1 = {r_sy[CB-1], r_sy, {rsqe_pkg::FRAC_BITS{1'b0}}};
    assign w_sx2 = {r_px[CB-1], r_px, {rsqe_pkg::FRAC_BITS{1'b0}}};
    assign w_sy2 = {r_py[CB-1], r_py, {rsqe_pkg::FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_odata <= {rsqe_pkg::sat_out(w_sy2 - w_oy), rsqe_pkg::sat_out(w_sx2 - w_ox),
                        rsqe_pkg::sat_out(w_sy1 - w_oy), rsqe_pkg::sat_out(w_sx1 - w_ox),
                        rsqe_pkg::sat_out(w_sy2 + w_oy), rsqe_pkg::sat_out(w_sx2 + w_ox),
                        rsqe_pkg::sat_out(w_sy1 + w_oy), rsqe_pkg::sat_out(w_sx1 + w_ox)};
            r_ozero <= r_zero;
            r_olast <= r_last;
        end
    end

    assign o_m_axis_tvalid   = r_ovalid;
    assign o_m_axis_tdata    = r_odata;
    assign o_m_axis_tuser[0] = r_ozero;
    assign o_m_axis_tlast    = r_olast;

    `RSQE_ASSERT_IMP(a_done_in_calc, i_clk, i_rst_n, w_rsp.done, r_state == rsqe_pkg::TS_CALC, "ratio done outside calculation")
    `RSQE_ASSERT_IMP(a_go_nonzero, i_clk, i_rst_n, r_go, !r_zero && r_state == rsqe_pkg::TS_CALC, "ratio started for zero-length segment")
    `RSQE_ASSERT_NXT(a_emit_fills, i_clk, i_rst_n, w_load, o_m_axis_tvalid && r_state == rsqe_pkg::TS_IDLE, "rectangle not presented after load")

endmodule

// ----- dv/road_segment_quad_expander_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the road segment quad expander: point stream in, rectangles checked out.
module road_segment_quad_expander_unit_test;

    localparam int CW = rsqe_pkg::COORD_BITS;
    localparam int OW = rsqe_pkg::OUT_BITS;
    localparam int DW = rsqe_pkg::DIST_BITS;
    localparam longint FRAC_SCALE = longint'(1) <<< rsqe_pkg::FRAC_BITS;

    // no transaction on either side for this long means the block is hung
    localparam int IDLE_LIMIT    = 3000;
    // a segment keeps the block busy through both bit searches; allow margin
    localparam int SETTLE_CYCLES = 120;

    // receiver back-pressure styles
    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;
    // how the next point of a random way moves away from the previous one
    typedef enum {STEP_SHORT, STEP_STILL, STEP_VERTICAL, STEP_LEVEL, STEP_JUMP} step_kind_t;

    typedef struct packed {
        logic [8*OW-1:0] corners;  // start_right_x in the low bits, end_left_y at the top
        logic            closes;
        logic            zero_len;
    } rect_t;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_cfg_we        = 1'b0;
    logic [DW-1:0]     i_cfg_wdata     = '0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [2*CW-1:0]   i_s_axis_tdata  = '0;  // point_x, point_y
    logic [0:0]        i_s_axis_tuser  = '0;  // first_of_way
    logic              i_s_axis_tlast  = 1'b0;  // last_of_way
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [8*OW-1:0]   o_m_axis_tdata;  // 8 corner coordinates, start_right_x lowest
    logic [0:0]        o_m_axis_tuser;  // zero_length
    logic              o_m_axis_tlast;  // closes_way

    road_segment_quad_expander_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the register and the way tracker
    // ------------------------------------------------------------------
    logic [DW-1:0]          road_half_width = rsqe_pkg::DIST_RESET;
    logic signed [CW-1:0]   prev_x    = '0;
    logic signed [CW-1:0]   prev_y    = '0;
    bit                     prev_open = 1'b0;  // a previous point of this way is held

    rect_t pending_rects[$];  // rectangles predicted but not yet seen on m_axis
    int    mismatch_count = 0;

    string corner_name [8] = '{"start_right_x", "start_right_y", "end_right_x", "end_right_y",
                               "start_left_x", "start_left_y", "end_left_x", "end_left_y"};

    // sender burst bookkeeping
    int burst_left = 0;
    bit pt_hold    = 1'b0;  // tvalid currently held high by the sender

    // ------------------------------------------------------------------
    // Offset magnitude: round(d * a / sqrt(a^2 + b^2)), ties away from zero.
    // Largest q <= d with (2q-1)^2 * (a^2+b^2) <= (2*d*a)^2, found bit by bit,
    // so it is exact with no square root.
    // ------------------------------------------------------------------
    function automatic logic [DW-1:0] rounded_share(input logic [DW-1:0] d,
                                                    input logic [127:0] a,
                                                    input logic [127:0] b);
        logic [127:0] bound, len_sq, m, q, cand;
        q      = '0;
        len_sq = a * a + b * b;
        bound  = 128'(2) * d * a;
        bound  = bound * bound;
        for (int k = DW; k >= 0; k--) begin
            cand = q | (128'(1) << k);
            if (cand <= 128'(d)) begin
                m = 2 * cand - 1;
                if (m * m * len_sq <= bound) q = cand;
            end
        end
        return q[DW-1:0];
    endfunction

    // clamp to the signed output range
    function automatic logic [OW-1:0] clamp_corner(input longint v);
        longint top = (longint'(1) <<< (OW - 1)) - 1;
        if (v > top) v = top;
        if (v < -top - 1) v = -top - 1;
        return v[OW-1:0];
    endfunction

    // Applies one accepted point to the way tracker; queues a rectangle when
    // the point closes a segment of the current way.
    function automatic void predict_rectangle(input logic signed [CW-1:0] x,
                                              input logic signed [CW-1:0] y,
                                              input bit first, input bit last);
        longint       dx, dy, ox, oy, sx1, sy1, sx2, sy2;
        logic [127:0] adx, ady;
        logic [DW-1:0] mx, my;
        bit           neg;
        rect_t        r;
        if (first) prev_open = 1'b0;
        if (prev_open) begin
            dx  = longint'(prev_x) - longint'(x);
            dy  = longint'(y) - longint'(prev_y);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            ox  = 0;
            oy  = 0;
            r.zero_len = (dx == 0) && (dy == 0);
            r.closes   = last;
            if (!r.zero_len) begin
                mx  = rounded_share(road_half_width, ady, adx);
                my  = rounded_share(road_half_width, adx, ady);
                // sign goes on after rounding; a level segment keeps ox positive
                neg = (dy != 0) && ((dx < 0) != (dy < 0));
                ox  = neg ? -longint'(mx) : longint'(mx);
                oy  = longint'(my);
            end
            sx1 = longint'(prev_x) * FRAC_SCALE;
            sy1 = longint'(prev_y) * FRAC_SCALE;
            sx2 = longint'(x) * FRAC_SCALE;
            sy2 = longint'(y) * FRAC_SCALE;
            r.corners = {clamp_corner(sy2 - oy), clamp_corner(sx2 - ox),
                         clamp_corner(sy1 - oy), clamp_corner(sx1 - ox),
                         clamp_corner(sy2 + oy), clamp_corner(sx2 + ox),
                         clamp_corner(sy1 + oy), clamp_corner(sx1 + ox)};
            pending_rects.push_back(r);
        end
        prev_x    = x;
        prev_y    = y;
        prev_open = !last;
    endfunction

    task automatic report_mismatch(input string what, input logic [OW-1:0] got,
                                   input logic [OW-1:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Compares one m_axis transaction with the oldest prediction.
    task automatic check_rectangle();
        rect_t want;
        if (pending_rects.size() == 0) begin
            report_mismatch("rectangle with none expected", o_m_axis_tdata[OW-1:0], '0);
            return;
        end
        want = pending_rects.pop_front();
        for (int k = 0; k < 8; k++) begin
            if (o_m_axis_tdata[k*OW +: OW] !== want.corners[k*OW +: OW])
                report_mismatch(corner_name[k], o_m_axis_tdata[k*OW +: OW],
                                want.corners[k*OW +: OW]);
        end
        if (o_m_axis_tlast !== want.closes)
            report_mismatch("closes_way", OW'(o_m_axis_tlast), OW'(want.closes));
        if (o_m_axis_tuser[0] !== want.zero_len)
            report_mismatch("zero_length", OW'(o_m_axis_tuser[0]), OW'(want.zero_len));
    endtask

    // ------------------------------------------------------------------
    // Receiver: checks every m_axis transaction, then drives its own
    // back-pressure pattern, switching style every so often.
    // ------------------------------------------------------------------
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;
    int       rx_tick    = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) check_rectangle();
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   i_m_axis_tready <= 1'b1;
            RX_COIN:   i_m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   i_m_axis_tready <= ((rx_tick % 37) < 6);
        endcase
    end

    // Watchdog: ends the run if neither side completes a transaction for too long.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready === 1'b1) ||
            (o_m_axis_tvalid === 1'b1 && i_m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender: one point per transaction, in bursts with random gaps between.
    // tvalid stays high across a burst; it is only raised when it is low.
    // ------------------------------------------------------------------
    task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                              input bit first, input bit last);
        int gap;
        if (!pt_hold) begin
            i_s_axis_tvalid <= 1'b1;
            pt_hold = 1'b1;
        end
        i_s_axis_tdata <= {y, x};
        i_s_axis_tuser <= first;
        i_s_axis_tlast <= last;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        predict_rectangle(x, y, first, last);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 24);
            i_s_axis_tvalid <= 1'b0;
            pt_hold = 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // Drops tvalid, waits for every predicted rectangle, then lets the block go idle.
    task automatic settle_block();
        if (pt_hold) begin
            i_s_axis_tvalid <= 1'b0;
            pt_hold = 1'b0;
        end
        while (pending_rects.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write only while idle; no handshake on this port.
    task automatic set_distance(input logic [DW-1:0] d);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        road_half_width = d;
    endtask

    // full range, hugging either extreme, or near the origin
    function automatic logic signed [CW-1:0] pick_coord();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 1) ? (1 << (CW - 1)) - 1 - $urandom_range(0, 63)
                                        : -(1 << (CW - 1)) + $urandom_range(0, 63);
            default: v = $urandom_range(0, 2000) - 1000;
        endcase
        return v[CW-1:0];
    endfunction

    // Mostly well-formed ways (first flag, run of points, last flag) with random
    // geometry; roughly one in ten ways carries random flags instead.
    task automatic run_random_ways(input int n_items);
        int sent, way_len;
        logic signed [CW-1:0] x, y;
        bit noisy, first, last;
        sent = 0;
        while (sent < n_items) begin
            way_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 10);
            noisy   = ($urandom_range(0, 9) == 0);
            x = pick_coord();
            y = pick_coord();
            for (int k = 0; k < way_len; k++) begin
                if (k > 0) begin
                    case (step_kind_t'($urandom_range(0, 5)))
                        STEP_STILL:    ;
                        STEP_VERTICAL: y = y + CW'(int'($urandom_range(0, 4000)) - 2000);
                        STEP_LEVEL:    x = x + CW'(int'($urandom_range(0, 4000)) - 2000);
                        STEP_JUMP: begin
                            x = pick_coord();
                            y = pick_coord();
                        end
                        default: begin
                            x = x + CW'(int'($urandom_range(0, 200)) - 100);
                            y = y + CW'(int'($urandom_range(0, 200)) - 100);
                        end
                    endcase
                end
                first = noisy ? 1'($urandom_range(0, 1))
                              : (k == 0) && ($urandom_range(0, 15) != 0);
                last  = noisy ? ($urandom_range(0, 3) == 0)
                              : (k == way_len - 1) && ($urandom_range(0, 15) != 0);
                send_point(x, y, first, last);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Way bookkeeping at the reset distance: every segment direction and
    // each way-boundary corner case.
    task automatic test_way_flags();
        send_point(10, 10, 0, 0);   // no previous point yet after reset
        send_point(20, 10, 0, 0);   // level segment
        send_point(20, 30, 0, 0);   // vertical, upwards
        send_point(20, 5, 0, 0);    // vertical, downwards
        send_point(20, 5, 0, 0);    // zero length
        send_point(23, 9, 0, 0);    // 3-4-5 diagonal
        send_point(50, 50, 1, 0);   // new way drops the held point
        send_point(40, 60, 0, 1);   // closes the way
        send_point(41, 61, 0, 0);   // after a way ends: starts afresh without first flag
        send_point(45, 58, 0, 1);
        send_point(7, 7, 1, 1);     // both flags: lone point
        send_point(8, 9, 0, 1);     // still no previous point
    endtask

    // Coordinate extremes, saturation at full distance, and zero distance.
    task automatic test_coordinate_extremes();
        localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
        localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
        set_distance({DW{1'b1}});
        send_point(CMIN, CMIN, 1, 0);
        send_point(CMAX, CMAX, 0, 0);   // full diagonal, corners clip
        send_point(CMIN, CMAX, 0, 0);   // full level span
        send_point(CMIN, CMIN, 0, 0);   // full vertical span
        send_point(CMAX, CMIN, 0, 1);
        set_distance('0);
        send_point(0, 0, 1, 0);
        send_point(100, -3, 0, 0);
        send_point(100, -3, 0, 1);
    endtask

    // Random ways under a range of distances, extremes included.
    task automatic test_distance_sweep();
        logic [DW-1:0] widths [8];
        widths = '{16'd1, 16'd255, 16'd32768, {DW{1'b1}}, 16'd0,
                   DW'($urandom), DW'($urandom), DW'($urandom_range(0, 2048))};
        foreach (widths[k]) begin
            set_distance(widths[k]);
            run_random_ways(50);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_way_flags();
        test_coordinate_extremes();
        test_distance_sweep();
        settle_block();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
